// ----- rtl/rgbm_pixel_encoder_macros.svh -----
// assertion macros for the rgbm pixel encoder
`ifndef RGBM_PIXEL_ENCODER_MACROS_SVH
`define RGBM_PIXEL_ENCODER_MACROS_SVH

// condition must hold at every clock while out of reset
`define RGBM_ASSERT_ALWAYS(lbl, ck, rstn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define RGBM_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/rgbm_pkg.sv -----
// types, constants and divider step functions for the rgbm pixel encoder
`default_nettype none

package rgbm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 24;
	localparam int RNG_W     = 7;
	localparam int CH_W      = RNG_W + FRAC_BITS;     // clamped channel width
	localparam int MNUM_W    = CH_W + 8;              // 255 * max + D - 1
	localparam int DIV_W     = RNG_W + 8;             // range * m
	localparam int CNUM_W    = CH_W + 16;             // channel * 65025
	localparam int NSTG      = 11;
	localparam logic [RNG_W-1:0] RANGE_RESET = RNG_W'(6);

	// stage 1: clamped channels
	typedef struct packed {
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic [RNG_W-1:0] rng;
		logic             last;
	} clamp_t;

	// multiplier division stages
	typedef struct packed {
		logic [MNUM_W-1:0] rem;
		logic [7:0]        quo;
		logic [CH_W-1:0]   r;
		logic [CH_W-1:0]   g;
		logic [CH_W-1:0]   b;
		logic [RNG_W-1:0]  rng;
		logic              last;
	} mdiv_t;

	// channel division stages
	typedef struct packed {
		logic [CNUM_W-1:0] rrem;
		logic [CNUM_W-1:0] grem;
		logic [CNUM_W-1:0] brem;
		logic [7:0]        rq;
		logic [7:0]        gq;
		logic [7:0]        bq;
		logic [DIV_W-1:0]  div;
		logic [7:0]        m;
		logic              last;
	} cdiv_t;

	// two restoring steps of (255 * max + D - 1) / D, quotient bits hi and hi-1
	function automatic mdiv_t mdiv_step2(mdiv_t x, logic [2:0] hi);
		mdiv_t             y;
		logic [MNUM_W-1:0] dsh;
		logic [2:0]        bi;
		y = x;
		for (int k = 0; k < 2; k++) begin
			bi  = hi - 3'(k);
			dsh = {{(MNUM_W-CH_W){1'b0}}, y.rng, {FRAC_BITS{1'b0}}} << bi;
			if (y.rem >= dsh) begin
				y.rem     = y.rem - dsh;
				y.quo[bi] = 1'b1;
			end
		end
		return y;
	endfunction

	// one restoring step of one channel against divisor (range * m) << FRAC_BITS
	function automatic logic [CNUM_W:0] cdiv_bit(logic [CNUM_W-1:0] rem,
			logic [DIV_W-1:0] div, logic [2:0] bi);
		logic [CNUM_W-1:0] dsh;
		logic [CNUM_W:0]   res;
		dsh = {{(CNUM_W-DIV_W-FRAC_BITS){1'b0}}, div, {FRAC_BITS{1'b0}}} << bi;
		if (rem >= dsh) res = {1'b1, rem - dsh};
		else            res = {1'b0, rem};
		return res;
	endfunction

	// two restoring steps on all three channels
	function automatic cdiv_t cdiv_step2(cdiv_t x, logic [2:0] hi);
		cdiv_t           y;
		logic [CNUM_W:0] t;
		logic [2:0]      bi;
		y = x;
		for (int k = 0; k < 2; k++) begin
			bi = hi - 3'(k);
			t = cdiv_bit(y.rrem, y.div, bi);
			y.rrem = t[CNUM_W-1:0];
			y.rq[bi] = t[CNUM_W];
			t = cdiv_bit(y.grem, y.div, bi);
			y.grem = t[CNUM_W-1:0];
			y.gq[bi] = t[CNUM_W];
			t = cdiv_bit(y.brem, y.div, bi);
			y.brem = t[CNUM_W-1:0];
			y.bq[bi] = t[CNUM_W];
		end
		return y;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rgbm_pixel_encoder.sv -----
// rgbm pixel encoder: hdr pixel in, rgba8 with shared multiplier in alpha out
//
// channel   direction  handshake             payload
// s_*       in         s_tvalid / s_tready   s_tdata red, green, blue; s_tlast end of image
// m_*       out        m_tvalid / m_tready   m_tdata red, green, blue, mult; m_tlast
// cfg_*     in         cfg_valid / cfg_ready cfg_data range_max
//
// eleven register stages: clamp, numerator, four stages of multiplier division
// (two quotient bits each), multiply, four stages of channel division
// one pixel per clock sustained while m_tready stays high
// each stage holds its item only while the stage after it is full and stalled,
// so bubbles collapse and a stalled output never blocks earlier empty stages
// arst_n clears all valid bits and sets range_max to 6; cfg_ready is always high
`default_nettype none
`include "rgbm_pixel_encoder_macros.svh"

module rgbm_pixel_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // red_in, green_in, blue_in
	input  wire logic        s_tlast,   // end_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // red_out, green_out, blue_out, mult_out
	output logic             m_tlast,   // end_out
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [rgbm_pkg::RNG_W-1:0] cfg_data  // range_max
);
	import rgbm_pkg::*;

	logic [RNG_W-1:0] range_q;
	logic [NSTG:1]    vld_q;
	logic [NSTG+1:1]  adv;

	clamp_t s1;
	mdiv_t  s2, s3, s4, s5, s6;
	cdiv_t  s7, s8, s9, s10, s11;

	logic [RNG_W-1:0] rng_in;
	logic [IN_W-1:0]  dlim;
	logic [IN_W-1:0]  r_raw, g_raw, b_raw;
	logic [CH_W-1:0]  mx_s1;
	logic [7:0]       m_s6;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RESET;
		end else if (cfg_valid) begin
			range_q <= cfg_data;
		end
	end

	// stage advance chain from the output back
	always_comb begin
		adv[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end
	assign s_tready = adv[1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1 clamp inputs to the range
	assign rng_in = (range_q == '0) ? RNG_W'(1) : range_q;
	assign dlim   = {{(IN_W-CH_W){1'b0}}, rng_in, {FRAC_BITS{1'b0}}};
	assign r_raw  = s_tdata[IN_W-1:0];
	assign g_raw  = s_tdata[2*IN_W-1:IN_W];
	assign b_raw  = s_tdata[3*IN_W-1:2*IN_W];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			s1.r    <= (r_raw < dlim) ? r_raw[CH_W-1:0] : dlim[CH_W-1:0];
			s1.g    <= (g_raw < dlim) ? g_raw[CH_W-1:0] : dlim[CH_W-1:0];
			s1.b    <= (b_raw < dlim) ? b_raw[CH_W-1:0] : dlim[CH_W-1:0];
			s1.rng  <= rng_in;
			s1.last <= s_tlast;
		end
	end

	// stage 2 largest channel and ceiling numerator
	always_comb begin
		mx_s1 = (s1.r > s1.g) ? s1.r : s1.g;
		if (s1.b > mx_s1) mx_s1 = s1.b;
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			s2.rem  <= {mx_s1, 8'd0} - MNUM_W'(mx_s1)
				+ {{(MNUM_W-CH_W){1'b0}}, s1.rng, {FRAC_BITS{1'b0}}} - MNUM_W'(1);
			s2.quo  <= '0;
			s2.r    <= s1.r;
			s2.g    <= s1.g;
			s2.b    <= s1.b;
			s2.rng  <= s1.rng;
			s2.last <= s1.last;
		end
	end

	// stages 3 to 6 multiplier division, two bits per stage
	always_ff @(posedge clk) begin
		if (adv[3]) s3 <= mdiv_step2(s2, 3'd7);
		if (adv[4]) s4 <= mdiv_step2(s3, 3'd5);
		if (adv[5]) s5 <= mdiv_step2(s4, 3'd3);
		if (adv[6]) s6 <= mdiv_step2(s5, 3'd1);
	end

	// stage 7 divisor range * m and numerators channel * 65025
	assign m_s6 = (s6.quo == 8'd0) ? 8'd1 : s6.quo;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			s7.rrem <= {s6.r, 16'd0} - CNUM_W'({s6.r, 9'd0}) + CNUM_W'(s6.r);
			s7.grem <= {s6.g, 16'd0} - CNUM_W'({s6.g, 9'd0}) + CNUM_W'(s6.g);
			s7.brem <= {s6.b, 16'd0} - CNUM_W'({s6.b, 9'd0}) + CNUM_W'(s6.b);
			s7.rq   <= '0;
			s7.gq   <= '0;
			s7.bq   <= '0;
			s7.div  <= DIV_W'(s6.rng) * DIV_W'(m_s6);
			s7.m    <= m_s6;
			s7.last <= s6.last;
		end
	end

	// stages 8 to 11 channel division, two bits per stage
	always_ff @(posedge clk) begin
		if (adv[8])  s8  <= cdiv_step2(s7, 3'd7);
		if (adv[9])  s9  <= cdiv_step2(s8, 3'd5);
		if (adv[10]) s10 <= cdiv_step2(s9, 3'd3);
		if (adv[11]) s11 <= cdiv_step2(s10, 3'd1);
	end

	// output
	assign m_tvalid = vld_q[NSTG];
	assign m_tdata  = {s11.m, s11.bq, s11.gq, s11.rq};
	assign m_tlast  = s11.last;

	// checks
	`RGBM_ASSERT_IMPL(a_mult_nonzero, clk, arst_n, m_tvalid, m_tdata[31:24] != 8'd0)
	`RGBM_ASSERT_IMPL(a_stall_source, clk, arst_n, !s_tready, m_tvalid && !m_tready)
	`RGBM_ASSERT_ALWAYS(a_range_nonzero, clk, arst_n, !vld_q[1] || s1.rng != '0)

endmodule

`default_nettype wire
